// ===== hdl/mcst_pkg.sv =====
// Shared types and constants of the multi-channel soft timer.
package mcst_pkg;

  localparam int CHANNELS   = 8;
  localparam int TIME_WIDTH = 32;

  // fixed field widths of the request and result items
  localparam int REQ_W      = 2;
  localparam int CHAN_W     = 3;
  localparam int PERIOD_W   = 32;
  localparam int MASK_OUT_W = 8;
  localparam int OUT_TIME_W = 32;

  localparam int CH_CMP_W   = 6;  // holds any channel number and CHANNELS itself
  localparam int CNT_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W     = $clog2(TIME_WIDTH);
  localparam int MASK_EXT_W = (CHANNELS > MASK_OUT_W) ? CHANNELS : MASK_OUT_W;

  typedef logic [TIME_WIDTH-1:0] time_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 2'd0,
    REQ_START_ONE = 2'd1,
    REQ_START_REP = 2'd2,
    REQ_DISABLE   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_MIN,
    ST_DONE
  } mcst_state_t;

  // broadcast from the controller to every channel cell
  typedef struct packed {
    logic      go;
    req_type_e op;
    time_t     now;
    time_t     per;
  } cell_cmd_t;

  typedef struct packed {
    logic fired;
    logic active;
    logic busy;
  } cell_stat_t;

endpackage

// ===== hdl/mcst_if.sv =====
// Request and result channel interfaces of the multi-channel soft timer.
interface mcst_in_if import mcst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [CHAN_W-1:0]   channel;
  logic [PERIOD_W-1:0] period_ms;

  modport source (output valid, req_type, channel, period_ms, input ready);
  modport sink   (input valid, req_type, channel, period_ms, output ready);
endinterface

interface mcst_out_if import mcst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MASK_OUT_W-1:0] fired_mask;
  logic [MASK_OUT_W-1:0] running_mask;
  logic [OUT_TIME_W-1:0] nearest_deadline;
  logic                  any_running;

  modport source (output valid, fired_mask, running_mask, nearest_deadline, any_running,
                  input ready);
  modport sink   (input valid, fired_mask, running_mask, nearest_deadline, any_running,
                  output ready);
endinterface

// ===== hdl/mcst_cell.sv =====
// One timer channel: deadline, period, mode, remainder unit and a stage of the minimum chain.
module mcst_cell import mcst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  logic       sel,
  input  time_t      min_in,
  output time_t      min_out,
  output cell_stat_t stat
);

  time_t             deadline_r, deadline_nxt;
  time_t             period_r, period_nxt;
  time_t             div_r, div_nxt;
  time_t             rem_r, rem_nxt;
  time_t             min_r, min_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              active_r, active_nxt;
  logic              rep_r, rep_nxt;
  logic              fired_r, fired_nxt;
  logic              busy_r, busy_nxt;

  logic                due;
  time_t               gap;
  logic [TIME_WIDTH:0] trial;
  logic                fits;
  time_t               rem_step;

  assign due      = active_r && (deadline_r <= cmd.now);
  assign gap      = cmd.now - deadline_r;
  assign trial    = {rem_r, div_r[TIME_WIDTH-1]};
  assign fits     = trial >= {1'b0, period_r};
  assign rem_step = fits ? TIME_WIDTH'(trial - {1'b0, period_r}) : trial[TIME_WIDTH-1:0];

  always_comb begin
    deadline_nxt = deadline_r;
    period_nxt   = period_r;
    div_nxt      = div_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    active_nxt   = active_r;
    rep_nxt      = rep_r;
    fired_nxt    = fired_r;
    busy_nxt     = busy_r;
    if (cmd.go) begin
      unique case (cmd.op)
        REQ_TICK: begin
          fired_nxt = due;
          if (due) begin
            if (rep_r) begin
              // zero period keeps the deadline, so the channel fires every tick
              if (period_r != '0) begin
                if (gap < period_r) begin
                  deadline_nxt = deadline_r + period_r;
                end else begin
                  // skipped periods: new deadline is now - gap % period + period
                  busy_nxt = 1'b1;
                  div_nxt  = gap;
                  rem_nxt  = '0;
                  step_nxt = STEP_W'(TIME_WIDTH - 1);
                end
              end
            end else begin
              active_nxt = 1'b0;
            end
          end
        end
        REQ_START_ONE, REQ_START_REP: begin
          fired_nxt = 1'b0;
          if (sel) begin
            period_nxt   = cmd.per;
            rep_nxt      = (cmd.op == REQ_START_REP);
            deadline_nxt = cmd.now + cmd.per;
            active_nxt   = 1'b1;
          end
        end
        REQ_DISABLE: begin
          fired_nxt = 1'b0;
          if (sel) begin
            active_nxt = 1'b0;
            rep_nxt    = 1'b0;
          end
        end
      endcase
    end else if (busy_r) begin
      rem_nxt  = rem_step;
      div_nxt  = div_r << 1;
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt     = 1'b0;
        deadline_nxt = cmd.now - rem_step + period_r;
      end
    end
  end

  assign min_nxt = (active_r && (deadline_r < min_in)) ? deadline_r : min_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rep_r    <= 1'b0;
      fired_r  <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      rep_r    <= rep_nxt;
      fired_r  <= fired_nxt;
      busy_r   <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    period_r   <= period_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    min_r      <= min_nxt;
  end

  assign min_out      = min_r;
  assign stat.fired   = fired_r;
  assign stat.active  = active_r;
  assign stat.busy    = busy_r;

endmodule

// ===== hdl/multi_channel_soft_timer.sv =====
// Top level of the multi-channel soft timer: controller, channel cell row, result register.
// Each request passes the states STEP, DIV, MIN and DONE between acceptance and a loaded result.
// STEP applies it to all channel cells and DIV waits until no remainder unit is busy. In MIN the
// nearest deadline travels the registered minimum chain from cell to cell, and DONE loads the
// result register. That load waits while the previous result still sits unread in the output
// register. A tick on which a repeating channel with a nonzero period is due and has fallen at
// least one period behind keeps DIV waiting for that cell's bit-serial remainder unit; all
// cells run theirs in parallel. One request is in flight at a time. A new one is accepted in
// the idle cycle after the load, even while the previous result still waits in the output
// register.
module multi_channel_soft_timer import mcst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mcst_in_if.sink    in_ch,
  mcst_out_if.source out_ch
);

  mcst_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  time_t       now_r;
  req_type_e   req_r;
  logic [CH_CMP_W-1:0] ch_r;
  logic        ch_ok_r;
  time_t       per_r;

  logic [MASK_OUT_W-1:0] fired_mask_r;
  logic [MASK_OUT_W-1:0] running_mask_r;
  logic [OUT_TIME_W-1:0] nearest_r;
  logic                  any_running_r;
  logic                  out_valid_r;

  logic in_ready;
  logic cell_go;
  logic load_out;
  logic in_take;

  cell_cmd_t   cmd;
  cell_stat_t  stat [CHANNELS];
  time_t       chain [CHANNELS+1];
  logic [CHANNELS-1:0]   fired_vec, active_vec, busy_vec;
  logic [MASK_EXT_W-1:0] fired_ext, active_ext;

  assign in_take = in_ch.valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_DIV;
      ST_DIV:  if (!(|busy_vec)) state_nxt = ST_MIN;
      ST_MIN:  if (cnt_r == CNT_W'(CHANNELS - 1)) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready = 1'b0;
    cell_go  = 1'b0;
    load_out = 1'b0;
    cnt_nxt  = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_STEP: cell_go  = 1'b1;
      ST_DIV:  ;
      ST_MIN:  cnt_nxt  = cnt_r + 1'b1;
      ST_DONE: load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_take && (req_type_e'(in_ch.req_type) == REQ_TICK)) begin
        now_r <= now_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r   <= req_type_e'(in_ch.req_type);
      ch_r    <= CH_CMP_W'(in_ch.channel);
      ch_ok_r <= CH_CMP_W'(in_ch.channel) < CH_CMP_W'(CHANNELS);
      per_r   <= TIME_WIDTH'(in_ch.period_ms);
    end
    if (load_out) begin
      fired_mask_r   <= fired_ext[MASK_OUT_W-1:0];
      running_mask_r <= active_ext[MASK_OUT_W-1:0];
      nearest_r      <= OUT_TIME_W'(chain[CHANNELS]);
      any_running_r  <= |active_vec;
    end
  end

  assign cmd.go  = cell_go;
  assign cmd.op  = req_r;
  assign cmd.now = now_r;
  assign cmd.per = per_r;

  assign chain[0] = '1;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    mcst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .sel     (ch_ok_r && (ch_r == CH_CMP_W'(i))),
      .min_in  (chain[i]),
      .min_out (chain[i+1]),
      .stat    (stat[i])
    );
    assign fired_vec[i]  = stat[i].fired;
    assign active_vec[i] = stat[i].active;
    assign busy_vec[i]   = stat[i].busy;
  end

  assign fired_ext  = MASK_EXT_W'(fired_vec);
  assign active_ext = MASK_EXT_W'(active_vec);

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.fired_mask       = fired_mask_r;
  assign out_ch.running_mask     = running_mask_r;
  assign out_ch.nearest_deadline = nearest_r;
  assign out_ch.any_running      = any_running_r;

`ifndef SYNTHESIS
  a_take_starts_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_STEP))
    else $error("accepted request did not start a step");

  a_no_min_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIN) |-> !(|busy_vec))
    else $error("minimum sweep overlaps a remainder computation");

  a_busy_only_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) && (req_r != REQ_TICK)) |=> !(|busy_vec))
    else $error("remainder unit started on a non-tick request");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !any_running_r) |-> (nearest_r == OUT_TIME_W'(time_t'('1))))
    else $error("nearest deadline not all ones with no channel running");

  a_any_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((CHANNELS > MASK_OUT_W) || (any_running_r == (running_mask_r != '0))))
    else $error("any_running disagrees with running mask");
`endif

endmodule

// ===== sim/mcst_timer_checker.sv =====
// Scoreboard for the multi-channel soft timer: predicts each result and compares it.
module mcst_timer_checker import mcst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mcst_in_if   in_mon,
  mcst_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MASK_OUT_W-1:0] fired;
    logic [MASK_OUT_W-1:0] running;
    logic [OUT_TIME_W-1:0] nearest;
    logic                  any;
  } timer_status_t;

  time_t               now_ms;
  time_t               due_at    [CHANNELS];
  time_t               period_of [CHANNELS];
  logic [CHANNELS-1:0] armed;
  logic [CHANNELS-1:0] periodic;
  timer_status_t       status_q[$];

  // advance a late deadline by whole periods until it passes the count
  function automatic time_t catch_up(time_t due, time_t per, time_t now);
    logic [63:0] steps;
    if (per == '0) return due;
    steps = 64'((now - due) / per) + 64'd1;
    return due + time_t'(steps * 64'(per));
  endfunction

  function automatic timer_status_t predict_status(req_type_e op, logic [CHAN_W-1:0] ch,
                                                   time_t per);
    timer_status_t st;
    time_t         nearest;
    st      = '0;
    nearest = '1;
    if (op == REQ_TICK) begin
      now_ms = now_ms + 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        if (armed[c] && due_at[c] <= now_ms) begin
          if (c < MASK_OUT_W) st.fired[c] = 1'b1;
          if (periodic[c]) due_at[c] = catch_up(due_at[c], period_of[c], now_ms);
          else armed[c] = 1'b0;
        end
      end
    end else if (int'(ch) < CHANNELS) begin
      if (op == REQ_DISABLE) begin
        armed[ch]    = 1'b0;
        periodic[ch] = 1'b0;
      end else begin
        period_of[ch] = per;
        periodic[ch]  = (op == REQ_START_REP);
        due_at[ch]    = now_ms + per;
        armed[ch]     = 1'b1;
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if (armed[c]) begin
        if (c < MASK_OUT_W) st.running[c] = 1'b1;
        if (due_at[c] < nearest) nearest = due_at[c];
      end
    end
    st.nearest = OUT_TIME_W'(nearest);
    st.any     = |armed;
    return st;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    timer_status_t want;
    timer_status_t got;
    if (!rst_n) begin
      now_ms         = '0;
      armed          = '0;
      periodic       = '0;
      mismatch_count = 0;
      status_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        status_q.push_back(predict_status(req_type_e'(in_mon.req_type), in_mon.channel,
                                          time_t'(in_mon.period_ms)));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.fired_mask, out_mon.running_mask, out_mon.nearest_deadline,
                out_mon.any_running};
        if (status_q.size() == 0) begin
          $display("%0t: result with no request outstanding, actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = status_q.pop_front();
          check_field("fired_mask", 32'(want.fired), 32'(got.fired));
          check_field("running_mask", 32'(want.running), 32'(got.running));
          check_field("nearest_deadline", 32'(want.nearest), 32'(got.nearest));
          check_field("any_running", 32'(want.any), 32'(got.any));
        end
      end
    end
    pending_count = status_q.size();
  end

endmodule

// ===== sim/multi_channel_soft_timer_tb.sv =====
// Stimulus and verdict for the multi-channel soft timer testbench.
module multi_channel_soft_timer_tb import mcst_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic tx_burst;
  int   mismatch_count;
  int   pending_count;

  mcst_in_if  in_ch();
  mcst_out_if out_ch();

  multi_channel_soft_timer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mcst_timer_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(req_type_e op, logic [CHAN_W-1:0] ch, logic [PERIOD_W-1:0] per);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= op;
    in_ch.channel   <= ch;
    in_ch.period_ms <= per;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly short periods so channels fire; some near the top so deadlines wrap
  function automatic logic [PERIOD_W-1:0] pick_period();
    int                  sel;
    logic [PERIOD_W-1:0] p;
    sel = $urandom_range(0, 9);
    if (sel < 6) p = $urandom_range(1, 16);
    else if (sel < 8) p = $urandom_range(17, 400);
    else if (sel == 8) p = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else p = $urandom;
    if (p == '0) p = 1;
    return p;
  endfunction

  initial begin : result_sink
    int  stall;
    int  taken;
    logic rx_burst;
    out_ch.ready = 1'b0;
    taken        = 0;
    rx_burst     = 1'b0;
    @(negedge clk);
    forever begin
      // long hold-off so the block backs up into its request port
      if (taken == 150 || taken == 900) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int        r;
    req_type_e op;
    rst_n           = 1'b0;
    tx_burst        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = REQ_TICK;
    in_ch.channel   = '0;
    in_ch.period_ms = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(REQ_START_ONE, 3'd0, 32'd1);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_START_REP, 3'd7, 32'd1);
    send_req(REQ_START_ONE, 3'd3, 32'hFFFF_FFFF);   // deadline wraps below the count
    send_req(REQ_TICK,      3'd7, 32'hFFFF_FFFF);
    send_req(REQ_START_REP, 3'd5, 32'hFFFF_FFFE);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_START_ONE, 3'd1, 32'd5);
    send_req(REQ_START_REP, 3'd1, 32'd2);           // rearm while active
    send_req(REQ_START_ONE, 3'd2, 32'h8000_0000);
    send_req(REQ_START_REP, 3'd4, 32'h5555_5555);
    send_req(REQ_DISABLE,   3'd7, 32'd0);
    send_req(REQ_DISABLE,   3'd6, 32'hAAAA_AAAA);   // channel already idle
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_START_ONE, 3'd6, 32'hAAAA_AAAA);
    send_req(REQ_START_REP, 3'd3, 32'd3);
    send_req(REQ_DISABLE,   3'd1, 32'd0);
    send_req(REQ_DISABLE,   3'd2, 32'd0);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_TICK,      3'd0, 32'd0);
    send_req(REQ_TICK,      3'd0, 32'd0);

    repeat (1580) begin
      if ($urandom_range(0, 63) == 0) tx_burst = ~tx_burst;
      r = $urandom_range(0, 99);
      if (r < 50) op = REQ_TICK;
      else if (r < 68) op = REQ_START_ONE;
      else if (r < 86) op = REQ_START_REP;
      else op = REQ_DISABLE;
      send_req(op, CHAN_W'($urandom_range(0, 7)), pick_period());
    end
    in_ch.valid <= 1'b0;

    // sample on the falling edge, away from the scoreboard's update
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mcst_pkg.sv
hdl/mcst_if.sv
hdl/mcst_cell.sv
hdl/multi_channel_soft_timer.sv
sim/mcst_timer_checker.sv
sim/multi_channel_soft_timer_tb.sv
